[sv/ucdp_pkg.sv]
// Shared types and constants for the configuration descriptor parser.
`timescale 1ns / 1ps

package ucdp_pkg;

    // Descriptor type codes
    localparam logic [7:0] TYPE_CONFIG    = 8'd2;
    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

    // Positions at or past this limit are ignored
    localparam logic [15:0] POS_LIMIT = 16'hFFFF;

    // Header is nine bytes; a final byte below this position means a short blob
    localparam logic [15:0] MIN_LAST_POS = 16'd8;

    // Endpoint record limit and internal tally width
    localparam int MAX_ENDPOINTS = 16;
    localparam int TALLY_W       = 6;

    // Job queue between parser and record emitter
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    // One queue entry: an endpoint record, a summary, or both (endpoint first)
    typedef struct packed {
        logic        has_ep;
        logic        has_sum;
        logic [4:0]  ep_count;
        logic [39:0] ep_bytes;    // address, attributes, max packet lo/hi, interval
        logic        sum_status;
        logic [4:0]  sum_count;
        logic [31:0] hdr;         // value, interfaces, total length
        logic [31:0] ifc;         // number, class, subclass, protocol
    } ucdp_job_t;

endpackage

[sv/ucdp_front.sv]
// Byte parser: header capture, descriptor walk and job generation.
`timescale 1ns / 1ps

module ucdp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                data_valid,
    output logic                data_ready,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    input  logic                queue_full,
    output logic                job_push,
    output ucdp_pkg::ucdp_job_t job
);

    logic [15:0] pos_reg,    pos_next;
    logic [15:0] start_reg,  start_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  type_reg,   type_next;
    logic        stopped_reg, stopped_next;
    logic        hdr_err_reg, hdr_err_next;
    logic        iface_seen_reg, iface_seen_next;
    logic [31:0] hdr_reg,    hdr_next;
    logic [31:0] ifc_reg,    ifc_next;
    logic [ucdp_pkg::TALLY_W-1:0] tally_reg, tally_next;
    logic [7:0]  cap_reg  [6];
    logic [7:0]  cap_next [6];

    logic        accept;
    logic        active;
    logic [15:0] st_eff;
    logic [16:0] desc_end;
    logic [16:0] pos_plus;
    logic [15:0] diff;
    logic [7:0]  k;
    logic        last;
    logic        ep_fire;
    logic        bad;

    assign data_ready = !queue_full;
    assign accept     = data_valid && data_ready;
    assign active     = pos_reg != ucdp_pkg::POS_LIMIT;
    assign st_eff     = (pos_reg == 16'd0) ? {8'd0, data_byte} : start_reg;
    assign desc_end   = {1'b0, st_eff} + {9'd0, len_reg};
    assign pos_plus   = {1'b0, pos_reg} + 17'd1;
    assign diff       = pos_reg - st_eff;
    assign k          = diff[7:0];

    // Next-state for one accepted byte
    always_comb
    begin
        pos_next        = pos_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        type_next       = type_reg;
        stopped_next    = stopped_reg;
        hdr_err_next    = hdr_err_reg;
        iface_seen_next = iface_seen_reg;
        hdr_next        = hdr_reg;
        ifc_next        = ifc_reg;
        tally_next      = tally_reg;
        cap_next        = cap_reg;
        last            = 1'b0;
        ep_fire         = 1'b0;

        if (active)
        begin
            if (pos_reg == 16'd0)
                start_next = {8'd0, data_byte};
            if (pos_reg == 16'd1 && data_byte != ucdp_pkg::TYPE_CONFIG)
                hdr_err_next = 1'b1;
            if (pos_reg == 16'd2)
                hdr_next[7:0] = hdr_reg[7:0] | data_byte;
            if (pos_reg == 16'd3)
                hdr_next[15:8] = hdr_reg[15:8] | data_byte;
            if (pos_reg == 16'd4)
                hdr_next[23:16] = hdr_reg[23:16] | data_byte;
            if (pos_reg == 16'd5)
                hdr_next[31:24] = hdr_reg[31:24] | data_byte;

            // Descriptor walk
            if (!stopped_reg)
            begin
                if (pos_reg == st_eff)
                begin
                    len_next  = data_byte;
                    type_next = 8'd0;
                    for (int i = 0; i < 6; i++)
                        cap_next[i] = 8'd0;
                    if (data_byte < 8'd2)
                        stopped_next = 1'b1;
                end
                else if (pos_reg > st_eff && {1'b0, pos_reg} < desc_end)
                begin
                    if (k == 8'd1)
                        type_next = data_byte;
                    for (int i = 0; i < 6; i++)
                        if (k == 8'(i + 2))
                            cap_next[i] = data_byte;
                end

                last = !stopped_next && (pos_reg > st_eff) && (pos_plus == desc_end);
                if (last)
                begin
                    if (type_next == ucdp_pkg::TYPE_INTERFACE && !iface_seen_reg)
                    begin
                        ifc_next        = {cap_next[0], cap_next[3], cap_next[4], cap_next[5]};
                        iface_seen_next = 1'b1;
                    end
                    else if (type_next == ucdp_pkg::TYPE_ENDPOINT && iface_seen_reg &&
                             !hdr_err_next &&
                             tally_reg < ucdp_pkg::TALLY_W'(ucdp_pkg::MAX_ENDPOINTS))
                    begin
                        tally_next = tally_reg + 1'b1;
                        ep_fire    = 1'b1;
                    end
                    start_next = pos_plus[15:0];
                end
            end
            pos_next = pos_plus[15:0];
        end
    end

    // Job for the queue; a summary is built from the post-byte state
    assign bad = hdr_err_next || (pos_reg < ucdp_pkg::MIN_LAST_POS);

    always_comb
    begin
        job.has_ep     = ep_fire;
        job.has_sum    = final_byte;
        job.ep_count   = tally_next[4:0];
        job.ep_bytes   = {cap_next[4], cap_next[3], cap_next[2], cap_next[1], cap_next[0]};
        job.sum_status = bad || !iface_seen_next;
        job.sum_count  = bad ? 5'd0 : tally_next[4:0];
        job.hdr        = bad ? 32'd0 : hdr_next;
        job.ifc        = bad ? 32'd0 : ifc_next;
    end

    assign job_push = accept && (ep_fire || final_byte);

    // State update; the final byte returns everything to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            start_reg      <= '0;
            len_reg        <= '0;
            type_reg       <= '0;
            stopped_reg    <= 1'b0;
            hdr_err_reg    <= 1'b0;
            iface_seen_reg <= 1'b0;
            hdr_reg        <= '0;
            ifc_reg        <= '0;
            tally_reg      <= '0;
            for (int i = 0; i < 6; i++)
                cap_reg[i] <= '0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                pos_reg        <= '0;
                start_reg      <= '0;
                len_reg        <= '0;
                type_reg       <= '0;
                stopped_reg    <= 1'b0;
                hdr_err_reg    <= 1'b0;
                iface_seen_reg <= 1'b0;
                hdr_reg        <= '0;
                ifc_reg        <= '0;
                tally_reg      <= '0;
                for (int i = 0; i < 6; i++)
                    cap_reg[i] <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                start_reg      <= start_next;
                len_reg        <= len_next;
                type_reg       <= type_next;
                stopped_reg    <= stopped_next;
                hdr_err_reg    <= hdr_err_next;
                iface_seen_reg <= iface_seen_next;
                hdr_reg        <= hdr_next;
                ifc_reg        <= ifc_next;
                tally_reg      <= tally_next;
                cap_reg        <= cap_next;
            end
        end
    end

endmodule

[sv/ucdp_queue.sv]
// Short job queue between the parser and the record emitter.
`timescale 1ns / 1ps

module ucdp_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ucdp_pkg::ucdp_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ucdp_pkg::ucdp_job_t head_job
);

    ucdp_pkg::ucdp_job_t mem_reg [ucdp_pkg::QUEUE_DEPTH];
    logic [ucdp_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ucdp_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ucdp_pkg::CNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full       = count_reg == ucdp_pkg::CNT_W'(ucdp_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[sv/ucdp_back.sv]
// Record emitter: expands queued jobs into output records behind a register.
`timescale 1ns / 1ps

module ucdp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ucdp_pkg::ucdp_job_t head_job,
    output logic                pop,
    output logic                record_valid,
    input  logic                record_ready,
    output logic                record_kind,
    output logic                status,
    output logic [7:0]          config_value,
    output logic [7:0]          interface_total,
    output logic [15:0]         config_total_bytes,
    output logic [7:0]          iface_number,
    output logic [23:0]         iface_class_triple,
    output logic [4:0]          endpoint_count,
    output logic [7:0]          ep_address,
    output logic [7:0]          ep_attributes,
    output logic [15:0]         ep_max_packet,
    output logic [7:0]          ep_interval
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;   // endpoint half of a two-record job done
    logic        kind_reg,  kind_next;
    logic        status_reg, status_next;
    logic [31:0] hdr_reg,   hdr_next;
    logic [31:0] ifc_reg,   ifc_next;
    logic [4:0]  count_reg, count_next;
    logic [39:0] ep_reg,    ep_next;
    logic        load;

    assign load = !valid_reg || record_ready;

    // Pick the next record from the queue head
    always_comb
    begin
        valid_next  = valid_reg;
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        hdr_next    = hdr_reg;
        ifc_next    = ifc_reg;
        count_next  = count_reg;
        ep_next     = ep_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                if (head_job.has_ep && !phase_reg)
                begin
                    kind_next   = 1'b0;
                    status_next = 1'b0;
                    hdr_next    = '0;
                    ifc_next    = '0;
                    count_next  = head_job.ep_count;
                    ep_next     = head_job.ep_bytes;
                    if (head_job.has_sum)
                        phase_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    kind_next   = 1'b1;
                    status_next = head_job.sum_status;
                    hdr_next    = head_job.hdr;
                    ifc_next    = head_job.ifc;
                    count_next  = head_job.sum_count;
                    ep_next     = '0;
                    phase_next  = 1'b0;
                    pop         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        hdr_reg    <= hdr_next;
        ifc_reg    <= ifc_next;
        count_reg  <= count_next;
        ep_reg     <= ep_next;
    end

    assign record_valid       = valid_reg;
    assign record_kind        = kind_reg;
    assign status             = status_reg;
    assign config_value       = hdr_reg[31:24];
    assign interface_total    = hdr_reg[23:16];
    assign config_total_bytes = hdr_reg[15:0];
    assign iface_number       = ifc_reg[31:24];
    assign iface_class_triple = ifc_reg[23:0];
    assign endpoint_count     = count_reg;
    assign ep_address         = ep_reg[7:0];
    assign ep_attributes      = ep_reg[15:8];
    assign ep_max_packet      = ep_reg[31:16];
    assign ep_interval        = ep_reg[39:32];

endmodule

[sv/usb_config_descriptor_parser.sv]
// Top level of the USB configuration descriptor parser.
// Input channel (data_valid/data_ready): one blob byte per transfer, with
// final_byte set on the last byte of the blob.
// Output channel (record_valid/record_ready): endpoint records (record_kind 0)
// for each endpoint descriptor after the first interface, up to sixteen per
// blob and none after a bad header type, then one summary (record_kind 1) per
// blob carrying header fields, interface fields and status.
// Throughput: one byte per cycle while the job queue is not full. The parser
// updates its walk state in the cycle a byte is taken and pushes any records
// it causes into a four-entry job queue; the emitter drains that queue into
// the output register, loading each record from the queue head once that
// register is free. When the final byte also completes an endpoint, the
// summary follows the endpoint record, so such a job yields two output
// records; data_ready drops only while the job queue is full.
// Reset clears the parse state, empties the queue and drops record_valid.
// While the receiver holds record_ready low the output record holds and
// bytes keep being taken until the queue fills.
`timescale 1ns / 1ps

module usb_config_descriptor_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        record_valid,
    input  logic        record_ready,
    output logic        record_kind,
    output logic        status,
    output logic [7:0]  config_value,
    output logic [7:0]  interface_total,
    output logic [15:0] config_total_bytes,
    output logic [7:0]  iface_number,
    output logic [23:0] iface_class_triple,
    output logic [4:0]  endpoint_count,
    output logic [7:0]  ep_address,
    output logic [7:0]  ep_attributes,
    output logic [15:0] ep_max_packet,
    output logic [7:0]  ep_interval
);

    ucdp_pkg::ucdp_job_t push_job;
    ucdp_pkg::ucdp_job_t head_job;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    ucdp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .queue_full (full),
        .job_push   (push),
        .job        (push_job)
    );

    ucdp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    ucdp_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .head_valid         (head_valid),
        .head_job           (head_job),
        .pop                (pop),
        .record_valid       (record_valid),
        .record_ready       (record_ready),
        .record_kind        (record_kind),
        .status             (status),
        .config_value       (config_value),
        .interface_total    (interface_total),
        .config_total_bytes (config_total_bytes),
        .iface_number       (iface_number),
        .iface_class_triple (iface_class_triple),
        .endpoint_count     (endpoint_count),
        .ep_address         (ep_address),
        .ep_attributes      (ep_attributes),
        .ep_max_packet      (ep_max_packet),
        .ep_interval        (ep_interval)
    );

endmodule
